### hdl/quad_attitude_pid_mixer_assert.svh
// ----------------------------------------------------------------------------
// quad attitude pid mixer assertion macros
// concurrent checks that compile away when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef QUAD_ATTITUDE_PID_MIXER_ASSERT_SVH
`define QUAD_ATTITUDE_PID_MIXER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define QAPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at an edge out of reset
`define QAPM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define QAPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define QAPM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hdl/qapm_pkg.sv
// ----------------------------------------------------------------------------
// qapm_pkg
// shared widths, codes and operand bundle of the attitude pid mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qapm_pkg;

    localparam int AXES       = 3;
    localparam int PULSE_W    = 16;
    localparam int ANGLE_W    = 16;
    localparam int ERR_W      = 18;
    localparam int DIFF_W     = 19;
    localparam int INTEG_W    = 32;
    localparam int PROD_W     = 44;
    localparam int SUM_W      = 49;
    localparam int PID_W      = 12;
    localparam int THR_W      = 13;
    localparam int SCALED_W   = 13;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [1:0] AXIS_YAW = 2'd2;

    // gains times ten
    localparam int KP10_RP  = 10;
    localparam int KP10_YAW = 15;
    localparam int KI10     = 2;
    localparam int KD10     = 2;

    // +-90 degrees in q9.23
    localparam logic signed [INTEG_W-1:0] INTEG_LIM = 32'sd754974720;
    // +-90 degrees times ten in q.23
    localparam logic [SUM_W-1:0] PID_LIM = 49'd7549747200;
    // t*1500/pid_lim == t*5/(3*2^23): rounding offset and shift
    localparam logic [35:0] OUT_RND   = 36'd12582912;
    // ceil(2^17/3), exact for the 13 bit quotient input
    localparam logic [16:0] RECIP3    = 17'd43691;

    typedef enum logic [REG_IDX_W-1:0] {
        CFG_RC_MID       = 3'd0,
        CFG_RC_DEADZONE  = 3'd1,
        CFG_STICK_GAIN   = 3'd2,
        CFG_ESC_MIN      = 3'd3,
        CFG_ESC_FLOOR    = 3'd4,
        CFG_ESC_MAX      = 3'd5,
        CFG_SAMPLE_RATE  = 3'd6,
        CFG_SAMPLE_FRAC  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_STICK = 2'd0,
        MUL_ISTEP = 2'd1,
        MUL_DERIV = 2'd2,
        MUL_RECIP = 2'd3
    } mul_op_t;

    typedef struct packed {
        mul_op_t                    op;
        logic signed [16:0]         dev;
        logic [23:0]                stick_gain;
        logic signed [ERR_W-1:0]    err;
        logic [23:0]                period;
        logic signed [DIFF_W-1:0]   diff;
        logic [11:0]                rate;
        logic [SCALED_W-1:0]        scaled;
    } mul_req_t;

endpackage

### hdl/qapm_mul_unit.sv
// ----------------------------------------------------------------------------
// qapm_mul_unit
// shared signed multiplier with operand select and registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qapm_mul_unit (
    input  logic                                 aclk,
    input  qapm_pkg::mul_req_t                   req,
    output logic signed [qapm_pkg::PROD_W-1:0]   prod
);
    import qapm_pkg::*;

    logic signed [18:0]       opa;
    logic signed [24:0]       opb;
    logic signed [PROD_W-1:0] prod_reg;

    always_comb begin
        case (req.op)
            MUL_STICK: begin
                opa = 19'(req.dev);
                opb = $signed({1'b0, req.stick_gain});
            end
            MUL_ISTEP: begin
                opa = 19'(req.err);
                opb = $signed({1'b0, req.period});
            end
            MUL_DERIV: begin
                opa = req.diff;
                opb = $signed({13'd0, req.rate});
            end
            MUL_RECIP: begin
                opa = $signed({6'd0, req.scaled});
                opb = $signed({8'd0, RECIP3});
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(opa) * PROD_W'(opb);
    end

    assign prod = prod_reg;

endmodule

### hdl/quad_attitude_pid_mixer.sv
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer
// three-axis attitude pid with x-frame motor mixer, one control tick per beat
// ----------------------------------------------------------------------------
// channel  dir  bits  contents
// s_       in   128   tdata: roll_pulse, pitch_pulse, yaw_pulse, throttle_pulse,
//                     arm_pulse, roll_angle, pitch_angle, yaw_angle (16 each)
// m_       out  64+1  tdata: motor_right_front, motor_left_front,
//                     motor_left_back, motor_right_back; tuser: armed
// cfg_     in   24    write enable, 3 bit register index, write data
//
// armed beat, from accept to the next accept: the accept cycle,
//   eight sequencer steps per axis (four on the shared multiplier), one mix
// disarmed beat: straight from accept to the mix step, state cleared and motors at esc_min
// s_tready is high only in idle; the result sits in an output register, and
//   the mix step waits there only if the previous result is still untaken
// reset (aresetn low, synchronous) clears integrators, previous errors and
//   loads the register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_attitude_pid_mixer (
    input  logic         aclk,
    input  logic         aresetn,
    // roll, pitch, yaw, throttle, arm pulses, then roll, pitch, yaw angles
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    // motor_right_front, motor_left_front, motor_left_back, motor_right_back
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,
    // armed
    output logic         m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata
);
    import qapm_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SETP  = 10'b0000000010,
        S_ERR   = 10'b0000000100,
        S_STEP  = 10'b0000001000,
        S_INTEG = 10'b0000010000,
        S_SUM   = 10'b0000100000,
        S_SCALE = 10'b0001000000,
        S_DIV3  = 10'b0010000000,
        S_PID   = 10'b0100000000,
        S_MIX   = 10'b1000000000
    } state_t;

    // round to nearest, ties away from zero, arithmetic right shift
    function automatic logic signed [PROD_W-1:0] rnd_shr(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              sh
    );
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        q   = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
        return v[PROD_W-1] ? -$signed(q) : $signed(q);
    endfunction

    // idle test first, then max
    function automatic logic [15:0] motor_sat(
        input logic signed [16:0] v,
        input logic [15:0]        lo,
        input logic [15:0]        hi
    );
        logic [15:0] r;
        if (v < $signed({1'b0, lo})) begin
            r = lo;
        end else if (v > $signed({1'b0, hi})) begin
            r = hi;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // configuration registers
    logic [15:0] rc_mid_reg;
    logic [15:0] rc_deadzone_reg;
    logic [23:0] stick_gain_reg;
    logic [15:0] esc_min_reg;
    logic [15:0] esc_floor_reg;
    logic [15:0] esc_max_reg;
    logic [11:0] sample_rate_reg;
    logic [23:0] sample_frac_reg;

    // control
    state_t      state_reg, state_next;
    logic [1:0]  axis_cnt_reg, axis_cnt_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // loop state
    logic signed [INTEG_W-1:0] integ_reg [AXES];
    logic signed [INTEG_W-1:0] integ_next [AXES];
    logic signed [ERR_W-1:0]   prev_reg [AXES];
    logic signed [ERR_W-1:0]   prev_next [AXES];

    // latched beat and working values
    logic [PULSE_W-1:0]        pulse_reg [AXES];
    logic signed [ANGLE_W-1:0] angle_reg [AXES];
    logic [THR_W-1:0]          thr_reg;
    logic                      armed_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [SUM_W-1:0]   t_reg;
    logic [SCALED_W-1:0]       x_reg;
    logic                      neg_reg;
    logic signed [PID_W-1:0]   pid_reg [AXES];
    logic [63:0]               m_tdata_reg;
    logic                      m_tuser_reg;

    logic                      accept;
    logic                      armed_in;
    logic                      out_free;

    mul_req_t                  mul_req;
    logic signed [PROD_W-1:0]  mul_prod;

    // per axis datapath
    logic [PULSE_W-1:0]        pulse_cur;
    logic signed [ANGLE_W-1:0] angle_cur;
    logic signed [INTEG_W-1:0] integ_cur;
    logic signed [ERR_W-1:0]   prev_cur;
    logic signed [16:0]        dev;
    logic [16:0]               dev_mag;
    logic                      in_dz;
    logic signed [PROD_W-1:0]  sp_round;
    logic signed [15:0]        sp;
    logic signed [ERR_W-1:0]   e_new;
    logic signed [PROD_W-1:0]  integ_sum;
    logic signed [INTEG_W-1:0] integ_upd;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SUM_W-1:0]   kp_term;
    logic signed [SUM_W-1:0]   ki_term;
    logic signed [SUM_W-1:0]   kd_term;
    logic signed [SUM_W-1:0]   t_new;
    logic [SUM_W-1:0]          t_mag;
    logic [SUM_W-1:0]          t_clip;
    logic [35:0]               t_x5;
    logic [35:0]               t_x5_rnd;
    logic [10:0]               pid_mag;
    logic signed [PID_W-1:0]   pid_new;

    // mixer
    logic signed [16:0]        thr_s;
    logic signed [16:0]        r_s, p_s, y_s;
    logic [15:0]               mot_rf, mot_lf, mot_lb, mot_rb;
    logic [63:0]               mix_data;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign armed_in = (s_tdata[79:64] > rc_mid_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_mid_reg      <= 16'd4500;
            rc_deadzone_reg <= 16'd60;
            stick_gain_reg  <= 24'd251658;
            esc_min_reg     <= 16'd3000;
            esc_floor_reg   <= 16'd3300;
            esc_max_reg     <= 16'd6000;
            sample_rate_reg <= 12'd250;
            sample_frac_reg <= 24'd67109;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_RC_MID:      rc_mid_reg      <= cfg_wdata[15:0];
                CFG_RC_DEADZONE: rc_deadzone_reg <= cfg_wdata[15:0];
                CFG_STICK_GAIN:  stick_gain_reg  <= cfg_wdata;
                CFG_ESC_MIN:     esc_min_reg     <= cfg_wdata[15:0];
                CFG_ESC_FLOOR:   esc_floor_reg   <= cfg_wdata[15:0];
                CFG_ESC_MAX:     esc_max_reg     <= cfg_wdata[15:0];
                CFG_SAMPLE_RATE: sample_rate_reg <= cfg_wdata[11:0];
                CFG_SAMPLE_FRAC: sample_frac_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier: stick scale, integral step, derivative, divide by 3
    // ------------------------------------------------------------------
    always_comb begin
        mul_req            = '0;
        mul_req.dev        = dev;
        mul_req.stick_gain = stick_gain_reg;
        mul_req.err        = e_reg;
        mul_req.period     = sample_frac_reg;
        mul_req.diff       = diff;
        mul_req.rate       = sample_rate_reg;
        mul_req.scaled     = x_reg;
        case (state_reg)
            S_SETP:  mul_req.op = MUL_STICK;
            S_STEP:  mul_req.op = MUL_ISTEP;
            S_INTEG: mul_req.op = MUL_DERIV;
            S_DIV3:  mul_req.op = MUL_RECIP;
            default: mul_req.op = MUL_STICK;
        endcase
    end

    qapm_mul_unit u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    // ------------------------------------------------------------------
    // per axis arithmetic, each piece used in one sequencer step
    // ------------------------------------------------------------------
    assign pulse_cur = pulse_reg[axis_cnt_reg];
    assign angle_cur = angle_reg[axis_cnt_reg];
    assign integ_cur = integ_reg[axis_cnt_reg];
    assign prev_cur  = prev_reg[axis_cnt_reg];

    // stick deviation and dead zone
    assign dev     = $signed({1'b0, pulse_cur}) - $signed({1'b0, rc_mid_reg});
    assign dev_mag = dev[16] ? 17'(-dev) : 17'(dev);
    assign in_dz   = (dev_mag <= {1'b0, rc_deadzone_reg});

    // setpoint from the stick product, saturated to q9.7
    assign sp_round = rnd_shr(mul_prod, 16);
    always_comb begin
        if (in_dz) begin
            sp = '0;
        end else if (sp_round > 44'sd32767) begin
            sp = 16'sh7fff;
        end else if (sp_round < -44'sd32768) begin
            sp = 16'sh8000;
        end else begin
            sp = sp_round[15:0];
        end
    end
    assign e_new = ERR_W'(sp) - ERR_W'(angle_cur);

    // integrator update, clamped to +-90 degrees
    assign integ_sum = PROD_W'(integ_cur) + rnd_shr(mul_prod, 8);
    always_comb begin
        if (integ_sum > PROD_W'(INTEG_LIM)) begin
            integ_upd = INTEG_LIM;
        end else if (integ_sum < -PROD_W'(INTEG_LIM)) begin
            integ_upd = -INTEG_LIM;
        end else begin
            integ_upd = integ_sum[INTEG_W-1:0];
        end
    end

    // error difference, taken before the previous error is replaced
    assign diff = DIFF_W'(e_reg) - DIFF_W'(prev_cur);

    // pid sum in q.23 times ten; mul_prod holds diff*rate here
    always_comb begin
        if (axis_cnt_reg == AXIS_YAW) begin
            kp_term = (SUM_W'(e_reg) * SUM_W'(KP10_YAW)) <<< 16;
            ki_term = '0;
            kd_term = '0;
        end else begin
            kp_term = (SUM_W'(e_reg) * SUM_W'(KP10_RP)) <<< 16;
            ki_term = SUM_W'(integ_cur) * SUM_W'(KI10);
            kd_term = (SUM_W'(mul_prod) * SUM_W'(KD10)) <<< 16;
        end
    end
    assign t_new = kp_term + ki_term + kd_term;

    // clamp magnitude, then (|t|*5 + half) >> 23 ahead of the divide by 3
    assign t_mag    = t_reg[SUM_W-1] ? SUM_W'(-t_reg) : SUM_W'(t_reg);
    assign t_clip   = (t_mag > PID_LIM) ? PID_LIM : t_mag;
    assign t_x5     = (36'(t_clip) << 2) + 36'(t_clip);
    assign t_x5_rnd = t_x5 + OUT_RND;

    // quotient by 3 via reciprocal multiply
    assign pid_mag = mul_prod[27:17];
    assign pid_new = neg_reg ? -$signed({1'b0, pid_mag}) : $signed({1'b0, pid_mag});

    // ------------------------------------------------------------------
    // x-frame mixer and motor saturation
    // ------------------------------------------------------------------
    assign thr_s = $signed({4'd0, thr_reg});
    assign r_s   = 17'(pid_reg[0]);
    assign p_s   = 17'(pid_reg[1]);
    assign y_s   = 17'(pid_reg[2]);

    assign mot_rf = motor_sat(thr_s - r_s - p_s + y_s, esc_floor_reg, esc_max_reg);
    assign mot_lf = motor_sat(thr_s + r_s - p_s - y_s, esc_floor_reg, esc_max_reg);
    assign mot_lb = motor_sat(thr_s + r_s + p_s + y_s, esc_floor_reg, esc_max_reg);
    assign mot_rb = motor_sat(thr_s - r_s + p_s - y_s, esc_floor_reg, esc_max_reg);

    assign mix_data = armed_reg ? {mot_rb, mot_lb, mot_lf, mot_rf}
                                : {esc_min_reg, esc_min_reg, esc_min_reg, esc_min_reg};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        axis_cnt_next = axis_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        integ_next    = integ_reg;
        prev_next     = prev_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    axis_cnt_next = '0;
                    if (armed_in) begin
                        state_next = S_SETP;
                    end else begin
                        // disarmed: drop integrators and previous errors
                        for (int a = 0; a < AXES; a++) begin
                            integ_next[a] = '0;
                            prev_next[a]  = '0;
                        end
                        state_next = S_MIX;
                    end
                end
            end
            S_SETP:  state_next = S_ERR;
            S_ERR:   state_next = S_STEP;
            S_STEP:  state_next = S_INTEG;
            S_INTEG: begin
                integ_next[axis_cnt_reg] = integ_upd;
                state_next = S_SUM;
            end
            S_SUM: begin
                prev_next[axis_cnt_reg] = e_reg;
                state_next = S_SCALE;
            end
            S_SCALE: state_next = S_DIV3;
            S_DIV3:  state_next = S_PID;
            S_PID: begin
                if (axis_cnt_reg == 2'(AXES - 1)) begin
                    state_next = S_MIX;
                end else begin
                    axis_cnt_next = axis_cnt_reg + 2'd1;
                    state_next    = S_SETP;
                end
            end
            S_MIX: begin
                // hold here while the previous result is still untaken
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            axis_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
            integ_reg    <= '{default: '0};
            prev_reg     <= '{default: '0};
        end else begin
            state_reg    <= state_next;
            axis_cnt_reg <= axis_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            integ_reg    <= integ_next;
            prev_reg     <= prev_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int a = 0; a < AXES; a++) begin
                pulse_reg[a] <= s_tdata[PULSE_W*a +: PULSE_W];
                angle_reg[a] <= s_tdata[80 + ANGLE_W*a +: ANGLE_W];
            end
            thr_reg   <= s_tdata[63:51];
            armed_reg <= armed_in;
        end
        if (state_reg == S_ERR) begin
            e_reg <= e_new;
        end
        if (state_reg == S_SUM) begin
            t_reg <= t_new;
        end
        if (state_reg == S_SCALE) begin
            x_reg   <= t_x5_rnd[35:23];
            neg_reg <= t_reg[SUM_W-1];
        end
        if (state_reg == S_PID) begin
            pid_reg[axis_cnt_reg] <= pid_new;
        end
        if (state_reg == S_MIX && out_free) begin
            m_tdata_reg <= mix_data;
            m_tuser_reg <= armed_reg;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`include "quad_attitude_pid_mixer_assert.svh"

    `QAPM_ASSERT(a_axis_range, aclk, aresetn,
        axis_cnt_reg <= 2'(AXES - 1), "axis count past last axis")
    `QAPM_ASSERT(a_last_axis_mix, aclk, aresetn,
        (state_reg == S_PID && axis_cnt_reg == 2'(AXES - 1)) |=> (state_reg == S_MIX),
        "last axis did not go to mix")
    `QAPM_ASSERT(a_pid_bound, aclk, aresetn,
        (state_reg == S_PID) |-> (pid_mag <= 11'd1500), "pid output beyond 1500")
    `QAPM_ASSERT(a_integ_bound, aclk, aresetn,
        (integ_cur <= INTEG_LIM) && (integ_cur >= -INTEG_LIM), "integrator beyond limit")
    `QAPM_ASSERT_NEVER(a_valid_src, aclk, aresetn,
        $rose(m_tvalid_reg) && !$past(state_reg == S_MIX), "result raised outside mix step")

endmodule

### bench/quad_attitude_pid_mixer_tb.sv
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer_tb
// self-checking bench for the attitude pid mixer: control ticks go in on the
// s_ stream, motor commands come back on the m_ stream and are compared,
// field by field, against a shadow pid/mixer kept in a scoreboard class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_attitude_pid_mixer_tb;

    import qapm_pkg::*;

    // q9.23 integrator cap and q.23 (times ten) pid cap, both 90 degrees
    localparam longint INTEG_CAP       = 64'sd754974720;
    localparam longint PID_CAP         = 64'sd7549747200;
    localparam longint OUT_SPAN        = 64'sd1500;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     WATCHDOG_LIMIT  = 4000;
    localparam int     END_SETTLE      = 40;

    // one control tick, declared high field first so roll_pulse lands in [15:0]
    typedef struct packed {
        logic [ANGLE_W-1:0] yaw_angle;
        logic [ANGLE_W-1:0] pitch_angle;
        logic [ANGLE_W-1:0] roll_angle;
        logic [PULSE_W-1:0] arm_pulse;
        logic [PULSE_W-1:0] throttle_pulse;
        logic [PULSE_W-1:0] yaw_pulse;
        logic [PULSE_W-1:0] pitch_pulse;
        logic [PULSE_W-1:0] roll_pulse;
    } tick_t;

    // one result beat, laid out exactly as {m_tuser, m_tdata}
    typedef struct packed {
        logic        armed;
        logic [15:0] right_back;
        logic [15:0] left_back;
        logic [15:0] left_front;
        logic [15:0] right_front;
    } motor_cmd_t;

    typedef logic [CFG_DATA_W-1:0] reg_set_t [8];

    // ------------------------------------------------------------------------
    // shadow controller plus the queue of motor commands still owed
    // ------------------------------------------------------------------------
    class motor_scoreboard;
        logic [15:0] rc_mid, rc_deadzone, esc_min, esc_floor, esc_max;
        logic [23:0] stick_gain, period_frac;
        logic [11:0] rate_hz;
        longint      integ [AXES];
        longint      prev_err [AXES];
        motor_cmd_t  pending_cmds [$];
        int unsigned mismatches;

        function new();
            rc_mid      = 16'd4500;
            rc_deadzone = 16'd60;
            stick_gain  = 24'd251658;
            esc_min     = 16'd3000;
            esc_floor   = 16'd3300;
            esc_max     = 16'd6000;
            rate_hz     = 12'd250;
            period_frac = 24'd67109;
            mismatches  = 0;
            for (int a = 0; a < AXES; a++) begin
                integ[a]    = 0;
                prev_err[a] = 0;
            end
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_RC_MID:      rc_mid      = v[15:0];
                CFG_RC_DEADZONE: rc_deadzone = v[15:0];
                CFG_STICK_GAIN:  stick_gain  = v[23:0];
                CFG_ESC_MIN:     esc_min     = v[15:0];
                CFG_ESC_FLOOR:   esc_floor   = v[15:0];
                CFG_ESC_MAX:     esc_max     = v[15:0];
                CFG_SAMPLE_RATE: rate_hz     = v[11:0];
                CFG_SAMPLE_FRAC: period_frac = v[23:0];
                default: ;
            endcase
        endfunction

        // nearest, ties away from zero
        function longint round_div(longint num, longint den);
            longint mag;
            mag = (num < 0) ? -num : num;
            mag = (mag + den / 2) / den;
            return (num < 0) ? -mag : mag;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint stick_setpoint(logic [15:0] pulse);
            longint dev, mag;
            dev = longint'(pulse) - longint'(rc_mid);
            mag = (dev < 0) ? -dev : dev;
            if (mag <= longint'(rc_deadzone)) return 0;
            return clip(round_div(dev * longint'(stick_gain), 65536), -32768, 32767);
        endfunction

        // idle test first, so idle above max still gives idle for low demand
        function logic [15:0] motor_clamp(longint v);
            if (v < longint'(esc_floor)) return esc_floor;
            if (v > longint'(esc_max)) return esc_max;
            return 16'(v);
        endfunction

        function void note_tick(tick_t t);
            motor_cmd_t  c;
            logic [15:0] pulse [AXES];
            logic [15:0] ang [AXES];
            longint      pid [AXES];
            longint      err, step, diff, t_sum, thr, kp, ki, kd;
            pulse[0] = t.roll_pulse;
            pulse[1] = t.pitch_pulse;
            pulse[2] = t.yaw_pulse;
            ang[0]   = t.roll_angle;
            ang[1]   = t.pitch_angle;
            ang[2]   = t.yaw_angle;
            if (!(t.arm_pulse > rc_mid)) begin
                for (int a = 0; a < AXES; a++) begin
                    integ[a]    = 0;
                    prev_err[a] = 0;
                end
                c = '{armed: 1'b0, right_back: esc_min, left_back: esc_min,
                      left_front: esc_min, right_front: esc_min};
            end else begin
                for (int a = 0; a < AXES; a++) begin
                    // gains times ten, yaw is p only
                    kp = (a == AXIS_YAW) ? 15 : 10;
                    ki = (a == AXIS_YAW) ? 0 : 2;
                    kd = (a == AXIS_YAW) ? 0 : 2;
                    err  = stick_setpoint(pulse[a]) - longint'($signed(ang[a]));
                    step = round_div(err * longint'(period_frac), 256);
                    integ[a] = clip(integ[a] + step, -INTEG_CAP, INTEG_CAP);
                    diff  = err - prev_err[a];
                    t_sum = kp * err * 65536 + ki * integ[a]
                          + kd * diff * longint'(rate_hz) * 65536;
                    prev_err[a] = err;
                    t_sum  = clip(t_sum, -PID_CAP, PID_CAP);
                    pid[a] = round_div(t_sum * OUT_SPAN, PID_CAP);
                end
                thr = longint'(t.throttle_pulse >> 3);
                c.armed       = 1'b1;
                c.right_front = motor_clamp(thr - pid[0] - pid[1] + pid[2]);
                c.left_front  = motor_clamp(thr + pid[0] - pid[1] - pid[2]);
                c.left_back   = motor_clamp(thr + pid[0] + pid[1] + pid[2]);
                c.right_back  = motor_clamp(thr - pid[0] + pid[1] - pid[2]);
            end
            pending_cmds.push_back(c);
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_cmd(motor_cmd_t got);
            motor_cmd_t exp_c;
            if (pending_cmds.size() == 0) begin
                $error("motor beat with nothing outstanding: %h", got);
                mismatches++;
                return;
            end
            exp_c = pending_cmds.pop_front();
            compare_field("motor_right_front", exp_c.right_front, got.right_front);
            compare_field("motor_left_front", exp_c.left_front, got.left_front);
            compare_field("motor_left_back", exp_c.left_back, got.left_back);
            compare_field("motor_right_back", exp_c.right_back, got.right_back);
            compare_field("armed", 16'(exp_c.armed), 16'(got.armed));
        endfunction

        function int backlog();
            return pending_cmds.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // roll, pitch, yaw, throttle, arm pulses, roll, pitch, yaw angles
    logic [127:0]          s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // right front, left front, left back, right back motors
    logic [63:0]           m_tdata;
    // armed
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [2:0]            cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    motor_scoreboard ledger;

    // receiver pacing; requests for a long hold-off are counted so that
    // each side writes only its own counter
    int hold_requests = 0;
    int hold_served   = 0;
    int stall_left    = 0;
    bit steady_flow   = 1'b0;
    int quiet_cycles  = 0;

    always #5 aclk = ~aclk;

    quad_attitude_pid_mixer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // receiver: mostly ready, short stalls, now and then a long one, and a
    // very long hold-off when asked so the block backs up into s_tready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            stall_left  <= HOLD_OFF_CYCLES;
            m_tready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (steady_flow || $urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 99) < 88) ? $urandom_range(0, 3)
                                                      : $urandom_range(15, 60);
        end
    end

    // result monitor, one check per accepted motor beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.check_cmd(motor_cmd_t'({m_tuser, m_tdata}));
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int sender_gap();
        int pick;
        if (steady_flow) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays up across back-to-back beats, dropped only for a gap
    task automatic push_tick(tick_t t);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
        ledger.note_tick(t);
    endtask

    // wait out every owed beat, then stay quiet for settle more cycles
    task automatic drain_results(int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.backlog() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic load_settings(reg_set_t vals);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= cfg_idx_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            ledger.write_reg(cfg_idx_t'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic tick_t mk_tick(input int roll, pitch, yaw, thr, arm, ra, pa, ya);
        tick_t t;
        t.roll_pulse     = 16'(roll);
        t.pitch_pulse    = 16'(pitch);
        t.yaw_pulse      = 16'(yaw);
        t.throttle_pulse = 16'(thr);
        t.arm_pulse      = 16'(arm);
        t.roll_angle     = 16'(ra);
        t.pitch_angle    = 16'(pa);
        t.yaw_angle      = 16'(ya);
        return t;
    endfunction

    function automatic logic [15:0] stick_near(int mid, int spread);
        int v;
        v = mid + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    function automatic logic [15:0] angle_within(int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // mostly armed flight with sticks around centre, some disarms, some noise
    function automatic tick_t random_tick(int span);
        tick_t t;
        int    mid, spread, sp, pick;
        mid    = ledger.rc_mid;
        spread = int'(ledger.rc_deadzone) + 600;
        pick   = $urandom_range(0, 99);
        t      = {$urandom, $urandom, $urandom, $urandom};
        if (pick < 8) return t;
        sp = ($urandom_range(0, 9) == 0) ? 32767 : span;
        t.roll_pulse     = stick_near(mid, spread);
        t.pitch_pulse    = stick_near(mid, spread);
        t.yaw_pulse      = stick_near(mid, spread);
        t.throttle_pulse = 16'($urandom_range(20000, 56000));
        if (pick < 15 || mid == 65535)
            t.arm_pulse = 16'($urandom_range(0, mid));
        else
            t.arm_pulse = 16'($urandom_range(mid + 1, 65535));
        t.roll_angle  = angle_within(sp);
        t.pitch_angle = angle_within(sp);
        t.yaw_angle   = angle_within(sp);
        return t;
    endfunction

    task automatic run_random(int count, int span);
        repeat (count) push_tick(random_tick(span));
    endtask

    function automatic reg_set_t random_settings();
        reg_set_t r;
        r[CFG_RC_MID]      = {8'($urandom), 16'($urandom_range(1500, 7500))};
        r[CFG_RC_DEADZONE] = {8'($urandom), 16'($urandom_range(0, 200))};
        r[CFG_STICK_GAIN]  = $urandom_range(0, 1) ? 24'($urandom_range(60000, 400000))
                                                  : 24'($urandom);
        r[CFG_ESC_MIN]     = 24'($urandom);
        r[CFG_ESC_FLOOR]   = {8'($urandom), 16'($urandom_range(1500, 4000))};
        r[CFG_ESC_MAX]     = {8'($urandom), 16'($urandom_range(4000, 9000))};
        r[CFG_SAMPLE_RATE] = {12'($urandom), 12'($urandom_range(1, 4095))};
        r[CFG_SAMPLE_FRAC] = 24'($urandom);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        reg_set_t regs;
        ledger = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed beats on reset defaults: centre 4500, dead zone 60
        push_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0));                 // disarmed, all zero
        push_tick(mk_tick(4500, 4500, 4500, 36000, 4500, 0, 0, 0)); // arm at centre: off
        push_tick(mk_tick(4500, 4500, 4500, 36000, 4501, 0, 0, 0)); // just armed, level
        push_tick(mk_tick(4560, 4440, 4561, 36000, 4501, 0, 0, 0)); // dead zone edges
        push_tick(mk_tick(4439, 4561, 4440, 36000, 6000, 0, 0, 0));
        push_tick(mk_tick(0, 65535, 65535, 36000, 6000, 0, 0, 0));  // setpoint saturates
        push_tick(mk_tick(65535, 0, 0, 36000, 6000, 0, 0, 0));
        push_tick(mk_tick(4500, 4500, 4500, 36000, 6000, -32768, 32767, -32768));
        push_tick(mk_tick(4500, 4500, 4500, 36000, 6000, 32767, -32768, 32767));
        push_tick(mk_tick(4500, 4500, 4500, 0, 6000, 0, 0, 0));     // all motors at idle
        push_tick(mk_tick(4500, 4500, 4500, 65535, 6000, 0, 0, 0)); // all motors at max
        // steady error: integrator grows, derivative goes to zero
        repeat (4) push_tick(mk_tick(5000, 4200, 4500, 38000, 6000, -640, 384, 128));
        push_tick(mk_tick(5000, 4200, 4500, 38000, 65535, 1280, -1280, 0));
        push_tick(mk_tick(5000, 4200, 4500, 38000, 4499, 1280, -1280, 0)); // clears state
        push_tick(mk_tick(5000, 4200, 4500, 38000, 4501, 256, -256, 64));
        push_tick(mk_tick(65535, 65535, 65535, 65535, 65535, -1, -1, -1));
        push_tick(mk_tick(43690, 21845, 43690, 21845, 65535, 43690, 21845, 43690));
        push_tick(mk_tick(21845, 43690, 21845, 43690, 65535, 21845, 43690, 21845));
        run_random(230, 3000);
        drain_results(4);

        // widest settings: gain, max, rate and period at their top; centre, dead zone and idle at zero
        regs = '{24'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'h00FFFF, 24'hFFF, 24'hFFFFFF};
        load_settings(regs);
        run_random(200, 11520);
        drain_results(4);

        // centre at the top: the arm switch can never pass it
        regs = '{24'h00FFFF, 24'h00FFFF, 24'd0, 24'h00FFFF, 24'h00FFFF, 24'd0, 24'd0,
                 24'd0};
        load_settings(regs);
        run_random(30, 3000);
        drain_results(4);

        // idle above max, minimal gain, rate and period
        regs = '{24'd1500, 24'd0, 24'd1, 24'd1, 24'd6000, 24'd3000, 24'd1, 24'd1};
        load_settings(regs);
        run_random(150, 3000);
        drain_results(4);

        // zero rate and period, both sides flat out
        regs = '{24'd4500, 24'd60, 24'd251658, 24'd3000, 24'd3300, 24'd6000, 24'd0,
                 24'd0};
        load_settings(regs);
        steady_flow <= 1'b1;
        run_random(150, 3000);
        steady_flow <= 1'b0;
        drain_results(4);

        repeat (4) begin
            load_settings(random_settings());
            run_random(180, 4000);
            drain_results(4);
        end

        // back to defaults, with the receiver holding off while beats keep coming
        regs = '{24'd4500, 24'd60, 24'd251658, 24'd3000, 24'd3300, 24'd6000, 24'd250,
                 24'd67109};
        load_settings(regs);
        hold_requests <= hold_requests + 1;
        run_random(300, 3000);
        drain_results(END_SETTLE);

        if (ledger.mismatches == 0 && ledger.backlog() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/qapm_pkg.sv
hdl/qapm_mul_unit.sv
hdl/quad_attitude_pid_mixer.sv
bench/quad_attitude_pid_mixer_tb.sv
